// ----- hdl/ksp_pkg.sv -----
// ----------------------------------------------------------------------------
// ksp_pkg
// Shared constants, codes and types of the knot span search block.
// ----------------------------------------------------------------------------
package ksp_pkg;

   localparam int MAX_KNOTS_DEF   = 64;
   localparam int CMD_QUEUE_DEPTH = 2;
   localparam int RSP_QUEUE_DEPTH = 2;

   localparam int KNOT_W      = 32;
   localparam int INDEX_W     = 6;
   localparam int IDX_W       = 7;
   localparam int SPAN_W      = 6;
   localparam int MULT_W      = 7;
   localparam int DEG_W       = 4;
   localparam int TOL_W       = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_DEGREE    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COUNT     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOLERANCE = 2'd2;

   localparam logic [DEG_W-1:0] DEGREE_RESET    = 4'd3;
   localparam logic [IDX_W-1:0] COUNT_RESET     = 7'd8;
   localparam logic [TOL_W-1:0] TOLERANCE_RESET = 16'd1;

   typedef struct packed {
      logic [DEG_W-1:0] degree;
      logic [IDX_W-1:0] count;
      logic [TOL_W-1:0] tolerance;
   } ksp_cfg_type;

   typedef struct packed {
      logic                     is_query;
      logic [INDEX_W-1:0]       index;
      logic signed [KNOT_W-1:0] value;
   } ksp_cmd_type;

   typedef struct packed {
      logic [SPAN_W-1:0] span_index;
      logic [MULT_W-1:0] multiplicity;
   } ksp_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_STEP,
      ST_FETCH_B,
      ST_EVAL,
      ST_OUT
   } ksp_state_type;

   typedef enum logic [1:0] {
      PH_BOUND,
      PH_FWD,
      PH_BACK,
      PH_BIN
   } ksp_phase_type;

endpackage

// ----- hdl/knot_span_search.sv -----
// ----------------------------------------------------------------------------
// knot_span_search
// Knot table with span index search and knot multiplicity count.
// ----------------------------------------------------------------------------
// Usage:
//   Request queue: drive req_* and raise push; the item is taken at a clock
//   edge with push high and full low. req_op low loads req_knot_value into
//   table entry req_knot_index, req_op high queries req_param_u.
//   Result queue: while empty is low, rsp_span_index and
//   rsp_knot_multiplicity show the oldest result; pop high takes it.
//   Loads give no result. Registers are written through csr_we, csr_index
//   and csr_wdata; the user must write them only while the block is idle,
//   as the block itself does not enforce this. A load is written to the
//   table from the idle state. A query runs the multiplicity scan over the
//   knots in use; with at least 2 * degree + 2 of them it then runs the
//   domain checks and a binary search or a walk that checks one span after
//   another, then hands off its result. The single read port of the knot
//   table sets the pace. Items are worked one after the other.
//   A stalled result queue holds the sequencer; the two-entry request
//   queue keeps taking items until it fills.
//   Reset empties both queues and restores the registers to degree 3,
//   8 knots and tolerance 1. The knot table is not cleared.
// ----------------------------------------------------------------------------
module knot_span_search #(
   parameter int MAX_KNOTS = ksp_pkg::MAX_KNOTS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  push,
   output logic                                  full,
   input  logic                                  req_op,
   input  logic [ksp_pkg::INDEX_W-1:0]           req_knot_index,
   input  logic signed [ksp_pkg::KNOT_W-1:0]     req_knot_value,
   input  logic signed [ksp_pkg::KNOT_W-1:0]     req_param_u,
   output logic                                  empty,
   input  logic                                  pop,
   output logic [ksp_pkg::SPAN_W-1:0]            rsp_span_index,
   output logic [ksp_pkg::MULT_W-1:0]            rsp_knot_multiplicity,
   input  logic                                  csr_we,
   input  logic [ksp_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [ksp_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   import ksp_pkg::*;

   ksp_cfg_type cfg_ff, cfg_in;
   ksp_cmd_type cmd;
   ksp_rsp_type rsp_new, rsp_head;
   logic        cmd_pop, cmd_empty;
   logic        rsp_push, rsp_full;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_DEGREE:    cfg_in.degree    = csr_wdata[DEG_W-1:0];
            CSR_COUNT:     cfg_in.count     = csr_wdata[IDX_W-1:0];
            CSR_TOLERANCE: cfg_in.tolerance = csr_wdata[TOL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.degree    <= DEGREE_RESET;
         cfg_ff.count     <= COUNT_RESET;
         cfg_ff.tolerance <= TOLERANCE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ksp_front #(
      .MAX_KNOTS   (MAX_KNOTS),
      .QUEUE_DEPTH (CMD_QUEUE_DEPTH)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_op         (req_op),
      .req_knot_index (req_knot_index),
      .req_knot_value (req_knot_value),
      .req_param_u    (req_param_u),
      .push           (push),
      .full           (full),
      .cmd_pop        (cmd_pop),
      .cmd_empty      (cmd_empty),
      .cmd            (cmd)
   );

   ksp_back #(
      .MAX_KNOTS (MAX_KNOTS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_empty (cmd_empty),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp       (rsp_new)
   );

   ksp_fifo #(
      .DATA_W ($bits(ksp_rsp_type)),
      .DEPTH  (RSP_QUEUE_DEPTH)
   ) u_rsp_fifo (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .full  (rsp_full),
      .din   (rsp_new),
      .pop   (pop),
      .empty (empty),
      .dout  (rsp_head)
   );

   assign rsp_span_index        = rsp_head.span_index;
   assign rsp_knot_multiplicity = rsp_head.multiplicity;

   // sequencer never pushes a result into a full queue
   a_rsp_no_overflow: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full)
      else $error("result pushed while result queue full");

   // sequencer only takes an item that is waiting
   a_cmd_no_underflow: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> !cmd_empty)
      else $error("item taken from empty request queue");

   // both queues come out of reset empty
   a_reset_clears: assert property (@(posedge clock)
      reset |=> (empty && !full && cmd_empty))
      else $error("queues not empty after reset");

endmodule

// ----- hdl/ksp_fifo.sv -----
// ----------------------------------------------------------------------------
// ksp_fifo
// Small first-in first-out queue with full and empty flags.
// ----------------------------------------------------------------------------
module ksp_fifo #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  logic [DATA_W-1:0] din,
   input  logic              pop,
   output logic              empty,
   output logic [DATA_W-1:0] dout
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic [DATA_W-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full    = (count_ff == FULL_CNT);
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

// ----- hdl/ksp_front.sv -----
// ----------------------------------------------------------------------------
// ksp_front
// Accepts request items, marks each as a load or a query, drops loads outside the table and queues the rest.
// ----------------------------------------------------------------------------
module ksp_front #(
   parameter int MAX_KNOTS   = ksp_pkg::MAX_KNOTS_DEF,
   parameter int QUEUE_DEPTH = ksp_pkg::CMD_QUEUE_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_op,
   input  logic [ksp_pkg::INDEX_W-1:0]       req_knot_index,
   input  logic signed [ksp_pkg::KNOT_W-1:0] req_knot_value,
   input  logic signed [ksp_pkg::KNOT_W-1:0] req_param_u,
   input  logic                              push,
   output logic                              full,
   input  logic                              cmd_pop,
   output logic                              cmd_empty,
   output ksp_pkg::ksp_cmd_type              cmd
);

   import ksp_pkg::*;

   ksp_cmd_type cmd_new;
   logic        in_range;
   logic        keep;

   // a load outside the table is taken and dropped here
   always_comb begin
      cmd_new.is_query = (req_op == OP_QUERY);
      cmd_new.index    = req_knot_index;
      cmd_new.value    = cmd_new.is_query ? req_param_u : req_knot_value;
      in_range         = (int'(req_knot_index) < MAX_KNOTS);
      keep             = cmd_new.is_query || in_range;
   end

   ksp_fifo #(
      .DATA_W ($bits(ksp_cmd_type)),
      .DEPTH  (QUEUE_DEPTH)
   ) u_cmd_fifo (
      .clock (clock),
      .reset (reset),
      .push  (push && keep),
      .full  (full),
      .din   (cmd_new),
      .pop   (cmd_pop),
      .empty (cmd_empty),
      .dout  (cmd)
   );

endmodule

// ----- hdl/ksp_back.sv -----
// ----------------------------------------------------------------------------
// ksp_back
// Knot table and query sequencer: multiplicity scan, domain checks,
// clamping walks and binary span search over one memory read port.
// ----------------------------------------------------------------------------
module ksp_back #(
   parameter int MAX_KNOTS = ksp_pkg::MAX_KNOTS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ksp_pkg::ksp_cfg_type cfg,
   input  logic                 cmd_empty,
   input  ksp_pkg::ksp_cmd_type cmd,
   output logic                 cmd_pop,
   input  logic                 rsp_full,
   output logic                 rsp_push,
   output ksp_pkg::ksp_rsp_type rsp
);

   import ksp_pkg::*;

   localparam int ADDR_W  = (MAX_KNOTS > 1) ? $clog2(MAX_KNOTS) : 1;
   localparam int PROBE_W = $clog2(MAX_KNOTS + 1);
   localparam logic [PROBE_W-1:0] PROBE_LIMIT = PROBE_W'(MAX_KNOTS);

   logic signed [KNOT_W-1:0] knot_mem [MAX_KNOTS];
   logic signed [KNOT_W-1:0] rd_data_ff;
   logic                     mem_we;
   logic                     rd_en;
   logic [IDX_W-1:0]         rd_idx;

   ksp_state_type            state_ff, state_in;
   ksp_phase_type            phase_ff, phase_in;
   logic signed [KNOT_W-1:0] u_ff, u_in;
   logic signed [KNOT_W-1:0] ka_ff, ka_in;
   logic [IDX_W-1:0]         p_ff, p_in;
   logic [IDX_W-1:0]         m_ff, m_in;
   logic [IDX_W-1:0]         n_ff, n_in;
   logic                     short_ff, short_in;
   logic [IDX_W-1:0]         cursor_ff, cursor_in;
   logic [IDX_W-1:0]         lo_ff, lo_in;
   logic [IDX_W-1:0]         hi_ff, hi_in;
   logic [IDX_W-1:0]         b_idx_ff, b_idx_in;
   logic [PROBE_W-1:0]       probes_ff, probes_in;
   logic [IDX_W-1:0]         scan_idx_ff, scan_idx_in;
   logic                     scan_pend_ff, scan_pend_in;
   logic [MULT_W-1:0]        mult_ff, mult_in;
   logic [IDX_W-1:0]         span_ff, span_in;

   logic [IDX_W-1:0]         p_cfg, m_cfg;
   logic [IDX_W:0]           min_count;
   logic signed [KNOT_W+1:0] tol_w, neg_tol_w, rd_w, u_w, ka_w, u_diff, gap;
   logic                     in_tol, gap_empty;
   logic [IDX_W:0]           mid_sum_lo, mid_sum_hi, mid_sum_start;

   // knot table, one write or one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         knot_mem[ADDR_W'(cmd.index)] <= cmd.value;
      end
      if (rd_en) begin
         rd_data_ff <= knot_mem[ADDR_W'(rd_idx)];
      end
   end

   assign rsp.span_index   = span_ff[SPAN_W-1:0];
   assign rsp.multiplicity = mult_ff;

   always_comb begin
      p_cfg     = (cfg.degree == '0) ? IDX_W'(1) : IDX_W'(cfg.degree);
      m_cfg     = (int'(cfg.count) > MAX_KNOTS) ? IDX_W'(MAX_KNOTS) : cfg.count;
      min_count = {p_cfg, 1'b0} + (IDX_W + 1)'(2);

      tol_w     = {{(KNOT_W + 2 - TOL_W){1'b0}}, cfg.tolerance};
      neg_tol_w = -tol_w;
      rd_w      = {{2{rd_data_ff[KNOT_W-1]}}, rd_data_ff};
      u_w       = {{2{u_ff[KNOT_W-1]}}, u_ff};
      ka_w      = {{2{ka_ff[KNOT_W-1]}}, ka_ff};
      u_diff    = rd_w - u_w;
      gap       = rd_w - ka_w;
      in_tol    = (u_diff <= tol_w) && (u_diff >= neg_tol_w);
      gap_empty = (gap <= tol_w);

      mid_sum_lo    = {1'b0, lo_ff} + {1'b0, cursor_ff};
      mid_sum_hi    = {1'b0, cursor_ff} + {1'b0, hi_ff};
      mid_sum_start = {1'b0, p_ff} + {1'b0, n_ff} + (IDX_W + 1)'(1);
   end

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      u_in         = u_ff;
      ka_in        = ka_ff;
      p_in         = p_ff;
      m_in         = m_ff;
      n_in         = n_ff;
      short_in     = short_ff;
      cursor_in    = cursor_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      b_idx_in     = b_idx_ff;
      probes_in    = probes_ff;
      scan_idx_in  = scan_idx_ff;
      scan_pend_in = scan_pend_ff;
      mult_in      = mult_ff;
      span_in      = span_ff;
      cmd_pop      = 1'b0;
      mem_we       = 1'b0;
      rd_en        = 1'b0;
      rd_idx       = '0;
      rsp_push     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop = 1'b1;
               if (cmd.is_query) begin
                  u_in         = cmd.value;
                  p_in         = p_cfg;
                  m_in         = m_cfg;
                  n_in         = m_cfg - p_cfg - IDX_W'(2);
                  short_in     = ({1'b0, m_cfg} < min_count);
                  mult_in      = '0;
                  scan_idx_in  = '0;
                  scan_pend_in = 1'b0;
                  state_in     = ST_SCAN;
               end else begin
                  mem_we = 1'b1;
               end
            end
         end

         // reads stream out one per cycle, data is counted in the next cycle
         ST_SCAN: begin
            if (scan_idx_ff < m_ff) begin
               rd_en        = 1'b1;
               rd_idx       = scan_idx_ff;
               scan_idx_in  = scan_idx_ff + IDX_W'(1);
               scan_pend_in = 1'b1;
            end else begin
               scan_pend_in = 1'b0;
            end
            if (scan_pend_ff && in_tol) begin
               mult_in = mult_ff + MULT_W'(1);
            end
            if (scan_idx_ff >= m_ff && !scan_pend_ff) begin
               if (short_ff) begin
                  span_in  = '0;
                  state_in = ST_OUT;
               end else begin
                  phase_in = PH_BOUND;
                  state_in = ST_STEP;
               end
            end
         end

         ST_STEP: begin
            case (phase_ff)
               PH_BOUND: begin
                  rd_en    = 1'b1;
                  rd_idx   = p_ff;
                  b_idx_in = n_ff + IDX_W'(1);
                  state_in = ST_FETCH_B;
               end
               PH_FWD: begin
                  if (cursor_ff >= n_ff) begin
                     span_in  = cursor_ff;
                     state_in = ST_OUT;
                  end else begin
                     rd_en    = 1'b1;
                     rd_idx   = cursor_ff;
                     b_idx_in = cursor_ff + IDX_W'(1);
                     state_in = ST_FETCH_B;
                  end
               end
               PH_BACK: begin
                  if (cursor_ff <= p_ff) begin
                     span_in  = cursor_ff;
                     state_in = ST_OUT;
                  end else begin
                     rd_en    = 1'b1;
                     rd_idx   = cursor_ff;
                     b_idx_in = cursor_ff + IDX_W'(1);
                     state_in = ST_FETCH_B;
                  end
               end
               PH_BIN: begin
                  // unsorted table: give up and answer the last probe
                  if (probes_ff >= PROBE_LIMIT) begin
                     span_in  = cursor_ff;
                     state_in = ST_OUT;
                  end else begin
                     rd_en    = 1'b1;
                     rd_idx   = cursor_ff;
                     b_idx_in = cursor_ff + IDX_W'(1);
                     state_in = ST_FETCH_B;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end

         ST_FETCH_B: begin
            ka_in    = rd_data_ff;
            rd_en    = 1'b1;
            rd_idx   = b_idx_ff;
            state_in = ST_EVAL;
         end

         // rd_data_ff holds the upper knot of the pair here
         ST_EVAL: begin
            state_in = ST_STEP;
            case (phase_ff)
               PH_BOUND: begin
                  if (u_ff <= ka_ff) begin
                     phase_in  = PH_FWD;
                     cursor_in = p_ff;
                  end else if (u_ff >= rd_data_ff) begin
                     phase_in  = PH_BACK;
                     cursor_in = n_ff;
                  end else begin
                     phase_in  = PH_BIN;
                     lo_in     = p_ff;
                     hi_in     = n_ff + IDX_W'(1);
                     cursor_in = mid_sum_start[IDX_W:1];
                     probes_in = '0;
                  end
               end
               PH_FWD: begin
                  if (gap_empty) begin
                     cursor_in = cursor_ff + IDX_W'(1);
                  end else begin
                     span_in  = cursor_ff;
                     state_in = ST_OUT;
                  end
               end
               PH_BACK: begin
                  if (gap_empty) begin
                     cursor_in = cursor_ff - IDX_W'(1);
                  end else begin
                     span_in  = cursor_ff;
                     state_in = ST_OUT;
                  end
               end
               PH_BIN: begin
                  if (u_ff < ka_ff) begin
                     hi_in     = cursor_ff;
                     cursor_in = mid_sum_lo[IDX_W:1];
                     probes_in = probes_ff + PROBE_W'(1);
                  end else if (u_ff >= rd_data_ff) begin
                     lo_in     = cursor_ff;
                     cursor_in = mid_sum_hi[IDX_W:1];
                     probes_in = probes_ff + PROBE_W'(1);
                  end else begin
                     span_in  = cursor_ff;
                     state_in = ST_OUT;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end

         ST_OUT: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_BOUND;
         scan_pend_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         scan_pend_ff <= scan_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      u_ff        <= u_in;
      ka_ff       <= ka_in;
      p_ff        <= p_in;
      m_ff        <= m_in;
      n_ff        <= n_in;
      short_ff    <= short_in;
      cursor_ff   <= cursor_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      b_idx_ff    <= b_idx_in;
      probes_ff   <= probes_in;
      scan_idx_ff <= scan_idx_in;
      mult_ff     <= mult_in;
      span_ff     <= span_in;
   end

endmodule
